@@ hw/rtl/sml_obis_entry_extractor_core_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef SML_OBIS_ENTRY_EXTRACTOR_CORE_DEFINES_SVH
`define SML_OBIS_ENTRY_EXTRACTOR_CORE_DEFINES_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define SOBX_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("sobx check failed");

// Condition in this cycle implies a consequence in the next cycle.
`define SOBX_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("sobx check failed");

`endif

@@ hw/rtl/sobx_pkg.sv @@
`default_nettype none
package sobx_pkg;

    localparam logic [3:0] K_LIST   = 4'd0;
    localparam logic [3:0] K_STRING = 4'd1;
    localparam logic [3:0] K_U_LO   = 4'd2;
    localparam logic [3:0] K_U_16   = 4'd3;
    localparam logic [3:0] K_U_HI   = 4'd5;
    localparam logic [3:0] K_S_HI   = 4'd9;
    localparam logic [3:0] K_OTHER  = 4'd10;
    localparam logic [3:0] K_OTHER_HI = 4'd15;
    localparam logic [3:0] VKIND_NONE = 4'd15;

    localparam int CTX_MSG     = 0;
    localparam int CTX_CHOICE  = 1;
    localparam int CTX_GETLIST = 2;
    localparam int CTX_VAL     = 3;

    localparam logic [15:0] MT_GETLIST_RES = 16'h0701;
    localparam logic [7:0]  LEN_MSG        = 8'd6;
    localparam logic [7:0]  LEN_ENTRY      = 8'd7;
    localparam logic [7:0]  LEN_CHOICE     = 8'd2;
    localparam logic [7:0]  LEN_OBIS       = 8'd6;

    typedef struct packed {
        logic [47:0] obis_code;
        logic        unit_valid;
        logic [15:0] unit_code;
        logic        scaler_valid;
        logic [7:0]  scaler;
        logic [3:0]  value_kind;
        logic [3:0]  kept_len;
        logic [63:0] value_bytes;
    } t_sobx_res;

    typedef struct packed {
        logic msg;
        logic choice;
        logic getlist;
        logic val;
        logic entry;
    } t_sobx_go;

    function automatic logic is_unsigned_kind(input logic [3:0] k);
        return (k >= K_U_LO) && (k <= K_U_HI);
    endfunction

    // Low 16 bits of a big-endian read of min(len,4) leading bytes.
    function automatic logic [15:0] lead16(input logic [63:0] d, input logic [7:0] len);
        logic [15:0] v;
        case (len)
            8'd0: v = 16'h0000;
            8'd1: v = {8'h00, d[63:56]};
            8'd2: v = d[63:48];
            8'd3: v = d[55:40];
            default: v = d[47:32];
        endcase
        return v;
    endfunction

    // Low 8 bits of the same read.
    function automatic logic [7:0] lead8(input logic [63:0] d, input logic [7:0] len);
        logic [7:0] v;
        case (len)
            8'd0: v = 8'h00;
            8'd1: v = d[63:56];
            8'd2: v = d[55:48];
            8'd3: v = d[47:40];
            default: v = d[39:32];
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sobx_entry.sv @@
`default_nettype none
module sobx_entry
    import sobx_pkg::*;
#(
    parameter int VALUE_BYTES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tok,
    input  wire logic        i_begin,
    input  wire logic [3:0]  i_kind,
    input  wire logic [7:0]  i_len,
    input  wire logic [63:0] i_data,
    output logic             o_hit,
    output t_sobx_res        o_res
);

    typedef struct packed {
        logic        active;
        logic        open;
        logic [2:0]  idx;
        logic [7:0]  pend;
        logic        has_obis;
        logic        has_unit;
        logic        has_scaler;
        logic        has_value;
        logic [47:0] obis;
        logic [15:0] unit;
        logic [7:0]  scaler;
        logic [3:0]  vkind;
        logic [3:0]  vlen;
        logic [63:0] value;
    } t_ent;

    localparam t_ent ENT_CLR = '{vkind: VKIND_NONE, default: '0};
    localparam logic [3:0] VB = 4'(VALUE_BYTES);

    t_ent      r_e, n_e;
    logic      r_hit, n_hit;
    t_sobx_res r_res, n_res;

    logic [8:0]  v_p9;
    logic        v_fin;
    logic [3:0]  v_cnt;
    logic [63:0] v_keep;
    logic        v_prim;

    always_comb begin
        v_prim = (i_kind >= K_STRING) && (i_kind <= K_S_HI);
        v_cnt  = (i_len > 8'(VALUE_BYTES)) ? VB : i_len[3:0];
        for (int b = 0; b < 8; b++) begin
            v_keep[63-8*b -: 8] = (4'(b) < v_cnt) ? i_data[63-8*b -: 8] : 8'h00;
        end
    end

    always_comb begin
        n_e   = r_e;
        n_hit = r_hit;
        n_res = r_res;
        v_p9  = '0;
        v_fin = 1'b0;
        if (i_tok) begin
            n_hit = 1'b0;
            if (r_e.active) begin
                if (!r_e.open) begin
                    n_e.open = 1'b1;
                    n_e.pend = (i_kind == K_LIST) ? i_len : 8'd0;
                    case (r_e.idx)
                        3'd0: begin
                            if (i_kind == K_STRING && i_len == LEN_OBIS) begin
                                n_e.obis     = i_data[63:16];
                                n_e.has_obis = 1'b1;
                            end else begin
                                n_e = ENT_CLR;
                            end
                        end
                        3'd3: begin
                            if (is_unsigned_kind(i_kind)) begin
                                n_e.unit     = lead16(i_data, i_len);
                                n_e.has_unit = 1'b1;
                            end
                        end
                        3'd4: begin
                            if (i_kind >= K_U_LO && i_kind <= K_S_HI) begin
                                n_e.scaler     = lead8(i_data, i_len);
                                n_e.has_scaler = 1'b1;
                            end
                        end
                        3'd5: begin
                            n_e.vkind     = i_kind;
                            n_e.vlen      = 4'd0;
                            n_e.has_value = 1'b0;
                            if (v_prim) begin
                                n_e.value     = v_keep;
                                n_e.vlen      = v_cnt;
                                n_e.has_value = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    v_fin = n_e.open && (n_e.pend == 8'd0);
                end else begin
                    v_p9 = {1'b0, r_e.pend} - {8'd0, (r_e.pend != 8'd0)};
                    if (i_kind == K_LIST) begin
                        v_p9 = v_p9 + {1'b0, i_len};
                    end
                    n_e.pend = v_p9[8] ? 8'hFF : v_p9[7:0];
                    v_fin    = (n_e.pend == 8'd0);
                end
                if (v_fin) begin
                    n_e.open = 1'b0;
                    n_e.idx  = r_e.idx + 3'd1;
                    if (n_e.idx == 3'd7) begin
                        // The seventh field closes the entry.
                        n_hit              = n_e.has_obis && n_e.has_value;
                        n_res.obis_code    = n_e.obis;
                        n_res.unit_valid   = n_e.has_unit;
                        n_res.unit_code    = n_e.unit;
                        n_res.scaler_valid = n_e.has_scaler;
                        n_res.scaler       = n_e.scaler;
                        n_res.value_kind   = (n_e.vkind == K_STRING) ? 4'd0
                                                                     : n_e.vkind - 4'd1;
                        n_res.kept_len     = n_e.vlen;
                        n_res.value_bytes  = n_e.value;
                        n_e                = ENT_CLR;
                    end
                end
            end
        end
        if (i_begin) begin
            n_e        = ENT_CLR;
            n_e.active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e   <= ENT_CLR;
            r_hit <= 1'b0;
        end else begin
            r_e   <= n_e;
            r_hit <= n_hit;
        end
        r_res <= n_res;
    end

    assign o_hit = r_hit;
    assign o_res = r_res;

endmodule
`default_nettype wire

@@ hw/rtl/sml_obis_entry_extractor_core.sv @@
// From acceptance to the result register: the exec step runs the token, the pop step pops the
// finished list levels under an open list one at a time, the push step pushes a list, and the
// emit step hands on the result. No new request is taken before the emit step is left, and a
// stalled result holds the emit step. Reset (synchronous, active low) empties the list stack,
// clears all contexts, the message type and the entry assembler, and drops any pending result.
`default_nettype none
module sml_obis_entry_extractor_core
    import sobx_pkg::*;
#(
    parameter int MAX_DEPTH   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_kind,
    input  wire logic [7:0]  i_length,
    input  wire logic [63:0] i_data_bytes,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [47:0]      o_obis_code,
    output logic             o_unit_valid,
    output logic [15:0]      o_unit_code,
    output logic             o_scaler_valid,
    output logic signed [7:0] o_scaler,
    output logic [3:0]       o_value_kind,
    output logic [3:0]       o_value_len,
    output logic [63:0]      o_value_bytes
);

    // Depth counter holds 0..MAX_DEPTH; frame index addresses MAX_DEPTH frames.
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    // The sequencer: fetch the request, run the token through the entry assembler and
    // consume one element of the open list, pop finished levels one per cycle, push a
    // new list with its contexts, then hand the result to the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_PUSH,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [7:0]    r_rem  [MAX_DEPTH];
    logic [7:0]    r_fidx [MAX_DEPTH];
    logic [DW-1:0] r_sd;
    logic [3:0]    r_flags;
    logic [DW-1:0] r_cdep [4];
    logic [15:0]   r_mt;
    logic [3:0]    r_kind;
    logic [7:0]    r_len;
    logic [63:0]   r_data;
    logic          r_used;
    t_sobx_go      r_go;
    logic          r_ov;
    t_sobx_res     r_out;

    logic [AW-1:0] w_top;
    logic [DW-1:0] w_sdm1;
    logic          w_par;
    logic          w_full;
    logic [DW-1:0] w_nsd;
    logic [7:0]    w_pi;
    logic          w_hit;
    t_sobx_res     w_res;
    t_sobx_go      w_go;

    assign w_sdm1 = r_sd - DW'(1);
    assign w_top  = w_sdm1[AW-1:0];
    assign w_par  = (r_sd != '0);
    assign w_full = (r_sd == DW'(MAX_DEPTH));
    assign w_nsd  = w_full ? r_sd : r_sd + DW'(1);
    assign w_pi   = w_par ? r_fidx[w_top] : 8'd0;

    // Context openings are judged on the state before the token touches the stack.
    always_comb begin
        w_go.msg     = !r_flags[CTX_MSG] && (r_len == LEN_MSG);
        w_go.choice  = r_flags[CTX_MSG] && (r_cdep[CTX_MSG] == r_sd) && (w_pi == 8'd3)
                       && (r_len == LEN_CHOICE);
        w_go.getlist = r_flags[CTX_CHOICE] && (r_cdep[CTX_CHOICE] == r_sd) && (w_pi == 8'd1)
                       && (r_mt == MT_GETLIST_RES) && (r_len == LEN_ENTRY);
        w_go.val     = r_flags[CTX_GETLIST] && (r_cdep[CTX_GETLIST] == r_sd) && (w_pi == 8'd4);
        w_go.entry   = r_flags[CTX_VAL] && (r_cdep[CTX_VAL] == r_sd) && (r_len == LEN_ENTRY);
    end

    sobx_entry #(
        .VALUE_BYTES(VALUE_BYTES)
    ) u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (r_state == S_EXEC && r_used),
        .i_begin (r_state == S_PUSH && r_go.entry),
        .i_kind  (r_kind),
        .i_len   (r_len),
        .i_data  (r_data),
        .o_hit   (w_hit),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sd    <= '0;
            r_flags <= '0;
            r_mt    <= '0;
            r_ov    <= 1'b0;
            r_used  <= 1'b0;
            r_go    <= '0;
            for (int i = 0; i < MAX_DEPTH; i++) begin
                r_rem[i]  <= '0;
                r_fidx[i] <= '0;
            end
            for (int c = 0; c < 4; c++) begin
                r_cdep[c] <= '0;
            end
        end else begin
            // The emit step loads the output register itself.
            if (r_ov && !i_out_stall && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_kind;
                        r_len   <= i_length;
                        r_data  <= i_data_bytes;
                        r_used  <= (i_kind <= K_S_HI);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_go <= w_go;
                    if (!r_used) begin
                        r_state <= S_EMIT;
                    end else begin
                        // An unsigned first element of the message body sets its type.
                        if (r_kind != K_LIST && r_flags[CTX_CHOICE]
                                && r_cdep[CTX_CHOICE] == r_sd && w_par
                                && r_fidx[w_top] == 8'd0 && is_unsigned_kind(r_kind)) begin
                            r_mt <= lead16(r_data, r_len);
                        end
                        if (w_par && r_rem[w_top] != 8'd0) begin
                            r_rem[w_top]  <= r_rem[w_top] - 8'd1;
                            r_fidx[w_top] <= r_fidx[w_top] + 8'd1;
                        end
                        if (w_par) begin
                            r_state <= S_POP;
                        end else begin
                            r_state <= (r_kind == K_LIST) ? S_PUSH : S_EMIT;
                        end
                    end
                end
                S_POP: begin
                    if (w_par && r_rem[w_top] == 8'd0) begin
                        r_sd <= w_sdm1;
                        for (int c = 0; c < 4; c++) begin
                            if (r_flags[c] && w_sdm1 < r_cdep[c]) begin
                                r_flags[c] <= 1'b0;
                                r_cdep[c]  <= '0;
                                if (c == CTX_CHOICE) begin
                                    r_mt <= '0;
                                end
                            end
                        end
                    end else begin
                        r_state <= (r_kind == K_LIST) ? S_PUSH : S_EMIT;
                    end
                end
                S_PUSH: begin
                    // A list beyond the stack depth is not pushed.
                    if (!w_full) begin
                        r_rem[r_sd[AW-1:0]]  <= r_len;
                        r_fidx[r_sd[AW-1:0]] <= 8'd0;
                    end
                    r_sd <= w_nsd;
                    if (r_go.msg) begin
                        r_flags[CTX_MSG] <= 1'b1;
                        r_cdep[CTX_MSG]  <= w_nsd;
                    end
                    if (r_go.choice) begin
                        r_flags[CTX_CHOICE] <= 1'b1;
                        r_cdep[CTX_CHOICE]  <= w_nsd;
                        r_mt                <= '0;
                    end
                    if (r_go.getlist) begin
                        r_flags[CTX_GETLIST] <= 1'b1;
                        r_cdep[CTX_GETLIST]  <= w_nsd;
                    end
                    if (r_go.val) begin
                        r_flags[CTX_VAL] <= 1'b1;
                        r_cdep[CTX_VAL]  <= w_nsd;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Wait until the output register is free before moving on.
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= r_used && w_hit;
                        r_out   <= w_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_obis_code    = r_out.obis_code;
    assign o_unit_valid   = r_out.unit_valid;
    assign o_unit_code    = r_out.unit_code;
    assign o_scaler_valid = r_out.scaler_valid;
    assign o_scaler       = r_out.scaler;
    assign o_value_kind   = r_out.value_kind;
    assign o_value_len    = r_out.kept_len;
    assign o_value_bytes  = r_out.value_bytes;

endmodule
`default_nettype wire

@@ hw/rtl/sobx_checker.sv @@
`default_nettype none
`include "sml_obis_entry_extractor_core_defines.svh"
module sobx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_unit_valid,
    input wire logic [15:0] o_unit_code,
    input wire logic [3:0]  o_value_len
);

    // An accepted request moves the sequencer out of idle, so the input must stall right after it.
    `SOBX_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `SOBX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `SOBX_ASSERT_NOW(a_len_range, i_clk, i_rst_n, o_out_valid, o_value_len <= 4'd8)
    `SOBX_ASSERT_NOW(a_unit_zero, i_clk, i_rst_n, o_out_valid && !o_unit_valid,
                     o_unit_code == 16'd0)

endmodule

bind sml_obis_entry_extractor_core sobx_checker u_sobx_checker (.*);
`default_nettype wire
